FILE: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared assertion forms for checkers clocked by clk and reset by arst_n.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MMR_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MMR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/mmr_pkg.sv
// ---------------------------------------------------------------------------
// mmr_pkg
// Constants, codes and types shared by the message reassembler files.
// ---------------------------------------------------------------------------
package mmr_pkg;

	localparam int MAX_MESSAGE_BYTES = 4096;
	localparam int PACKET_MTU        = 64;
	localparam int TIME_WIDTH        = 32;

	localparam int ADDR_W = $clog2(MAX_MESSAGE_BYTES);
	localparam int LEN_W  = ADDR_W + 1;
	localparam int PLEN_W = 7;
	localparam int IDX_W  = 12;
	localparam int SEQ_W  = 2;

	localparam logic [TIME_WIDTH-1:0] TIMEOUT_RESET = TIME_WIDTH'(1000);

	// Item kinds.
	localparam logic [1:0] KIND_HEADER  = 2'd0;
	localparam logic [1:0] KIND_PAYLOAD = 2'd1;
	localparam logic [1:0] KIND_READ    = 2'd2;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_DONE     = 3'd1,
		ST_TIMEOUT  = 3'd2,
		ST_NOSOM    = 3'd3,
		ST_TAG      = 3'd4,
		ST_SEQ      = 3'd5,
		ST_OVERFLOW = 3'd6
	} status_t;

	typedef struct packed {
		logic [1:0]            kind;
		logic                  start_of_message;
		logic                  end_of_message;
		logic [2:0]            message_tag;
		logic                  tag_owner;
		logic [7:0]            message_type;
		logic [SEQ_W-1:0]      packet_sequence;
		logic [PLEN_W-1:0]     payload_length;
		logic [7:0]            data_byte;
		logic [IDX_W-1:0]      read_index;
		logic [TIME_WIDTH-1:0] time_now;
	} item_t;

	// Result of one item before the buffer read data joins it.
	typedef struct packed {
		status_t          status;
		logic [LEN_W-1:0] message_length;
		logic             read_valid;
	} result_t;

	// Buffer access requested by the control unit.
	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [7:0]        wdata;
		logic              re;
		logic [ADDR_W-1:0] raddr;
	} mem_req_t;

endpackage

FILE: rtl/mmr_req_if.sv
// ---------------------------------------------------------------------------
// mmr_req_if
// Input item channel of the message reassembler.
// ---------------------------------------------------------------------------
interface mmr_req_if import mmr_pkg::*; ();

	logic                  valid;
	logic                  ready;
	logic [1:0]            kind;
	logic                  start_of_message;
	logic                  end_of_message;
	logic [2:0]            message_tag;
	logic                  tag_owner;
	logic [7:0]            message_type;
	logic [SEQ_W-1:0]      packet_sequence;
	logic [PLEN_W-1:0]     payload_length;
	logic [7:0]            data_byte;
	logic [IDX_W-1:0]      read_index;
	logic [TIME_WIDTH-1:0] time_now;

	modport source (
		output valid, kind, start_of_message, end_of_message, message_tag, tag_owner,
		       message_type, packet_sequence, payload_length, data_byte, read_index,
		       time_now,
		input  ready
	);

	modport sink (
		input  valid, kind, start_of_message, end_of_message, message_tag, tag_owner,
		       message_type, packet_sequence, payload_length, data_byte, read_index,
		       time_now,
		output ready
	);

endinterface

FILE: rtl/mmr_rsp_if.sv
// ---------------------------------------------------------------------------
// mmr_rsp_if
// Result channel of the message reassembler.
// ---------------------------------------------------------------------------
interface mmr_rsp_if import mmr_pkg::*; ();

	logic             valid;
	logic             ready;
	logic [2:0]       status;
	logic [LEN_W-1:0] message_length;
	logic [7:0]       read_byte;
	logic             read_valid;

	modport source (
		output valid, status, message_length, read_byte, read_valid,
		input  ready
	);

	modport sink (
		input  valid, status, message_length, read_byte, read_valid,
		output ready
	);

endinterface

FILE: rtl/mmr_ram.sv
// ---------------------------------------------------------------------------
// mmr_ram
// Generic single-clock RAM, one write port and one read port, registered read.
// ---------------------------------------------------------------------------
module mmr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read data holds while no read is issued.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: rtl/mmr_ctrl.sv
// ---------------------------------------------------------------------------
// mmr_ctrl
// Assembly state, header checks and payload bookkeeping for one accepted item a cycle.
// ---------------------------------------------------------------------------
module mmr_ctrl import mmr_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [TIME_WIDTH-1:0] cfg_wdata,
	input  logic                  fire,
	input  item_t                 item,
	output result_t               result,
	output mem_req_t              mem_req
);

	typedef struct packed {
		logic                  assembling;
		logic [SEQ_W-1:0]      exp_seq;
		logic [2:0]            held_tag;
		logic                  held_owner;
		logic [7:0]            held_type;
		logic [TIME_WIDTH-1:0] last_time;
		logic [LEN_W-1:0]      asm_len;
		logic [PLEN_W-1:0]     bytes_rem;
		logic                  accepting;
		logic                  eom_pending;
	} asm_state_t;

	asm_state_t            asm_q, asm_d;
	logic [LEN_W-1:0]      cmp_len_q, cmp_len_d;
	logic [TIME_WIDTH-1:0] timeout_q;

	// The held type and the last packet time survive a cleared assembly.
	function automatic asm_state_t clear_asm(asm_state_t s);
		asm_state_t r;
		r             = '0;
		r.held_type   = s.held_type;
		r.last_time   = s.last_time;
		return r;
	endfunction

	always_comb begin
		asm_state_t            n;
		logic [TIME_WIDTH-1:0] gap;
		logic [LEN_W:0]        total;

		n       = asm_q;
		gap     = '0;
		total   = '0;
		asm_d   = asm_q;
		cmp_len_d = cmp_len_q;
		result  = '{status: ST_OK, message_length: '0, read_valid: 1'b0};
		mem_req = '0;

		if (fire) begin
			unique case (item.kind)
				KIND_HEADER: begin
					// A header arriving mid-packet drops the assembly first.
					if (n.accepting) begin
						n = clear_asm(n);
					end
					gap = item.time_now - n.last_time;
					if (n.assembling && (gap > timeout_q)) begin
						n = clear_asm(n);
						result.status = ST_TIMEOUT;
					end else begin
						if (item.start_of_message) begin
							n            = clear_asm(n);
							cmp_len_d    = '0;
							n.assembling = 1'b1;
							n.exp_seq    = item.packet_sequence;
							n.held_tag   = item.message_tag;
							n.held_owner = item.tag_owner;
							n.held_type  = item.message_type;
						end
						total = {1'b0, n.asm_len} + (LEN_W + 1)'(item.payload_length);
						priority if (!n.assembling) begin
							result.status = ST_NOSOM;
						end else if (item.message_tag != n.held_tag ||
						             item.tag_owner != n.held_owner) begin
							n = clear_asm(n);
							result.status = ST_TAG;
						end else if (item.message_type != n.held_type ||
						             item.packet_sequence != n.exp_seq) begin
							n = clear_asm(n);
							result.status = ST_SEQ;
						end else if (item.payload_length > PLEN_W'(PACKET_MTU) ||
						             total > (LEN_W + 1)'(MAX_MESSAGE_BYTES)) begin
							n = clear_asm(n);
							result.status = ST_OVERFLOW;
						end else begin
							n.last_time   = item.time_now;
							n.exp_seq     = n.exp_seq + 1'b1;
							n.bytes_rem   = item.payload_length;
							n.accepting   = (item.payload_length != '0);
							n.eom_pending = item.end_of_message;
							if (item.end_of_message && item.payload_length == '0) begin
								cmp_len_d             = n.asm_len;
								n                     = clear_asm(n);
								result.status         = ST_DONE;
								result.message_length = cmp_len_d;
							end
						end
					end
				end
				KIND_PAYLOAD: begin
					if (n.accepting) begin
						if (n.asm_len < LEN_W'(MAX_MESSAGE_BYTES)) begin
							mem_req.we    = 1'b1;
							mem_req.waddr = n.asm_len[ADDR_W-1:0];
							mem_req.wdata = item.data_byte;
							n.asm_len     = n.asm_len + 1'b1;
						end
						if (n.bytes_rem != '0) begin
							n.bytes_rem = n.bytes_rem - 1'b1;
						end
						if (n.bytes_rem == '0) begin
							n.accepting = 1'b0;
							if (n.eom_pending) begin
								cmp_len_d             = n.asm_len;
								n                     = clear_asm(n);
								result.status         = ST_DONE;
								result.message_length = cmp_len_d;
							end
						end
					end
				end
				KIND_READ: begin
					result.message_length = cmp_len_q;
					if ({1'b0, item.read_index} < cmp_len_q) begin
						result.read_valid = 1'b1;
						mem_req.re        = 1'b1;
						mem_req.raddr     = item.read_index[ADDR_W-1:0];
					end
				end
				default: begin
				end
			endcase
			asm_d = n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			asm_q     <= '0;
			cmp_len_q <= '0;
		end else begin
			asm_q     <= asm_d;
			cmp_len_q <= cmp_len_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RESET;
		end else if (cfg_we) begin
			timeout_q <= cfg_wdata;
		end
	end

endmodule

FILE: rtl/mctp_message_reassembler.sv
// ---------------------------------------------------------------------------
// mctp_message_reassembler
// Rebuilds messages from headed packets in a byte buffer and serves reads.
// ---------------------------------------------------------------------------
// Usage. Items arrive on the req channel: a packet header, one transfer per
// payload byte, or a read of a byte of the last completed message. Each
// accepted item gives exactly one result transfer on the rsp channel, in
// order: a status code, the completed length on completion and on reads, and
// the byte read with its valid flag.
// The user must write the timeout register through cfg_we and cfg_wdata only
// while the block is idle; the block does not enforce this. It takes effect
// on the next header. A result passes through the buffer read stage and the
// output register before it is offered on rsp. The block takes one item in
// every cycle while ready is high: the header checks and payload bookkeeping
// finish in the accept cycle, and each item makes at most one access to the
// single-ported-write, single-ported-read byte buffer.
// A result waiting in the output register does not hold up the input: the
// block keeps accepting until both the buffer read stage and the output
// register are full, then drops ready until rsp is taken.
// Reset clears all control state and sets the timeout to 1000 ticks at once;
// the buffer itself is not cleared, as only written bytes are ever read.
// ---------------------------------------------------------------------------
module mctp_message_reassembler import mmr_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	mmr_req_if.sink               req,
	mmr_rsp_if.source             rsp,
	input  logic                  cfg_we,
	input  logic [TIME_WIDTH-1:0] cfg_wdata
);

	item_t             item;
	result_t           result;
	mem_req_t          mem_req;
	logic              fire;
	logic              advance;
	logic [7:0]        rdata;

	// Buffer read stage: the result waits here for the RAM read data.
	logic              valid_s1;
	result_t           result_s1;

	// Output register.
	logic              out_valid_q;
	status_t           out_status_q;
	logic [LEN_W-1:0]  out_length_q;
	logic [7:0]        out_byte_q;
	logic              out_rvalid_q;

	assign item = '{
		kind:             req.kind,
		start_of_message: req.start_of_message,
		end_of_message:   req.end_of_message,
		message_tag:      req.message_tag,
		tag_owner:        req.tag_owner,
		message_type:     req.message_type,
		packet_sequence:  req.packet_sequence,
		payload_length:   req.payload_length,
		data_byte:        req.data_byte,
		read_index:       req.read_index,
		time_now:         req.time_now
	};

	// The read stage moves on whenever the output register is free or drains.
	assign advance   = valid_s1 && (!out_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || advance;
	assign fire      = req.valid && req.ready;

	mmr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.fire      (fire),
		.item      (item),
		.result    (result),
		.mem_req   (mem_req)
	);

	// Read data is only refreshed by an accepted read, so it holds while
	// the read stage is stalled.
	mmr_ram #(
		.WIDTH (8),
		.DEPTH (MAX_MESSAGE_BYTES)
	) u_buf (
		.clk   (clk),
		.we    (mem_req.we),
		.waddr (mem_req.waddr),
		.wdata (mem_req.wdata),
		.re    (mem_req.re),
		.raddr (mem_req.raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (fire) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			result_s1 <= result;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_status_q <= result_s1.status;
			out_length_q <= result_s1.message_length;
			out_rvalid_q <= result_s1.read_valid;
			out_byte_q   <= result_s1.read_valid ? rdata : 8'd0;
		end
	end

	assign rsp.valid          = out_valid_q;
	assign rsp.status         = out_status_q;
	assign rsp.message_length = out_length_q;
	assign rsp.read_byte      = out_byte_q;
	assign rsp.read_valid     = out_rvalid_q;

endmodule

FILE: rtl/mmr_checker.sv
// ---------------------------------------------------------------------------
// mmr_checker
// Port-level checks on the result channel of the message reassembler.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module mmr_checker import mmr_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             rsp_valid,
	input logic             rsp_ready,
	input logic [2:0]       status,
	input logic [LEN_W-1:0] message_length,
	input logic [7:0]       read_byte,
	input logic             read_valid
);

	logic is_error;

	// Any of the failed header checks.
	assign is_error = (status == ST_TIMEOUT) || (status == ST_NOSOM) || (status == ST_TAG) ||
	                  (status == ST_SEQ) || (status == ST_OVERFLOW);

	`MMR_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "result dropped")

	`MMR_ASSERT_SAME(a_read_ok, rsp_valid && read_valid, status == ST_OK, "bad read status")

	`MMR_ASSERT_SAME(a_byte_zero, rsp_valid && !read_valid, read_byte == 8'd0, "stray byte")

	`MMR_ASSERT_SAME(a_err_len, rsp_valid && is_error, message_length == '0, "length on error")

endmodule

bind mctp_message_reassembler mmr_checker u_mmr_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.status         (rsp.status),
	.message_length (rsp.message_length),
	.read_byte      (rsp.read_byte),
	.read_valid     (rsp.read_valid)
);

FILE: tb/mctp_message_reassembler_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mctp_message_reassembler_test
// Self-checking bench for the message reassembler. A behavioural copy of the
// reassembly rules predicts one outcome per accepted request transfer, and
// every response transfer is compared with the oldest prediction. Directed
// cases cover each header check, then randomised messages with occasional
// flaws run under several timeout settings with random idling on both sides.
// ---------------------------------------------------------------------------
module mctp_message_reassembler_test;
	import mmr_pkg::*;

	// A stretch of this many cycles with no transfer on either channel means
	// the block has hung.
	localparam int STALL_LIMIT = 2000;
	// Cycles allowed after the last response before the verdict.
	localparam int DRAIN_CYCLES = 8;
	localparam int RANDOM_ITEMS = 480;
	localparam int TIMEOUT_SETTINGS = 5;
	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam logic [TIME_WIDTH-1:0] TIME_MAX = '1;

	// Ways in which a random message may be spoilt.
	typedef enum int {
		FLAW_NONE,
		FLAW_TAG,
		FLAW_OWNER,
		FLAW_TYPE,
		FLAW_SEQ,
		FLAW_LATE,
		FLAW_NO_SOM,
		FLAW_OVERSIZE,
		FLAW_SHORT,
		FLAW_STRAY,
		FLAW_NOISE
	} flaw_t;

	typedef struct packed {
		status_t          status;
		logic [LEN_W-1:0] length;
		logic [7:0]       data;
		logic             valid;
	} outcome_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [TIME_WIDTH-1:0] cfg_wdata;

	mmr_req_if req_bus ();
	mmr_rsp_if rsp_bus ();

	mctp_message_reassembler u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_bus),
		.rsp       (rsp_bus),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Predicted copy of the block's state and of its timeout register.
	logic [TIME_WIDTH-1:0] gap_limit;
	logic                  assembling;
	logic [SEQ_W-1:0]      next_seq;
	logic [2:0]            held_tag;
	logic                  held_owner;
	logic [7:0]            held_type;
	logic [TIME_WIDTH-1:0] last_header_time;
	int unsigned           assembled_bytes;
	int unsigned           bytes_left;
	logic                  in_payload;
	logic                  eom_pending;
	int unsigned           completed_bytes;
	logic [7:0]            message_store [MAX_MESSAGE_BYTES];

	// Outcomes still owed by the block, oldest first.
	outcome_t expected_outcomes [$];
	outcome_t due;

	// Stimulus controls shared between the test tasks and the response side.
	logic                  source_idle = 1'b1;
	logic                  sink_idle = 1'b1;
	int unsigned           hold_request = 0;
	logic [TIME_WIDTH-1:0] stamp;

	int unsigned counted_items = 0;
	int unsigned checked_results = 0;
	int unsigned mismatches = 0;
	int unsigned status_seen [8];

	// Dropping an assembly keeps the last type and the time of the last
	// accepted header; everything else returns to its reset value.
	function automatic void abandon_assembly();
		assembling = 1'b0;
		next_seq = '0;
		held_tag = '0;
		held_owner = 1'b0;
		assembled_bytes = 0;
		bytes_left = 0;
		in_payload = 1'b0;
		eom_pending = 1'b0;
	endfunction

	function automatic outcome_t close_message();
		outcome_t res;
		res = '0;
		completed_bytes = assembled_bytes;
		abandon_assembly();
		res.status = ST_DONE;
		res.length = LEN_W'(completed_bytes);
		return res;
	endfunction

	// Works out the response to one accepted request and advances the
	// predicted state accordingly.
	function automatic outcome_t reassemble(item_t it);
		outcome_t              res;
		logic [TIME_WIDTH-1:0] elapsed;
		res = '0;
		case (it.kind)
			KIND_HEADER: begin
				// A header that cuts into an unfinished payload ends the assembly first.
				if (in_payload)
					abandon_assembly();
				elapsed = it.time_now - last_header_time;
				// The timeout wins over everything, a fresh SOM included.
				if (assembling && elapsed > gap_limit) begin
					abandon_assembly();
					res.status = ST_TIMEOUT;
					return res;
				end
				if (it.start_of_message) begin
					abandon_assembly();
					completed_bytes = 0;
					assembling = 1'b1;
					next_seq = it.packet_sequence;
					held_tag = it.message_tag;
					held_owner = it.tag_owner;
					held_type = it.message_type;
				end else if (!assembling) begin
					res.status = ST_NOSOM;
					return res;
				end
				if (it.message_tag != held_tag || it.tag_owner != held_owner) begin
					abandon_assembly();
					res.status = ST_TAG;
					return res;
				end
				if (it.message_type != held_type || it.packet_sequence != next_seq) begin
					abandon_assembly();
					res.status = ST_SEQ;
					return res;
				end
				if (it.payload_length > PACKET_MTU ||
						assembled_bytes + it.payload_length > MAX_MESSAGE_BYTES) begin
					abandon_assembly();
					res.status = ST_OVERFLOW;
					return res;
				end
				last_header_time = it.time_now;
				next_seq = next_seq + 1'b1;
				bytes_left = it.payload_length;
				in_payload = it.payload_length != 0;
				eom_pending = it.end_of_message;
				// An empty packet carrying EOM finishes the message straight away.
				if (it.end_of_message && it.payload_length == 0)
					return close_message();
			end
			KIND_PAYLOAD: begin
				// A byte with no payload expected is simply dropped.
				if (in_payload) begin
					if (assembled_bytes < MAX_MESSAGE_BYTES) begin
						message_store[assembled_bytes] = it.data_byte;
						assembled_bytes++;
					end
					if (bytes_left > 0)
						bytes_left--;
					if (bytes_left == 0) begin
						in_payload = 1'b0;
						if (eom_pending)
							return close_message();
					end
				end
			end
			KIND_READ: begin
				res.length = LEN_W'(completed_bytes);
				if (it.read_index < completed_bytes) begin
					res.data = message_store[it.read_index];
					res.valid = 1'b1;
				end
			end
			default: ;
		endcase
		return res;
	endfunction

	// Every field starts random, so that the fields a kind does not use
	// still toggle; the builders below then set the fields that matter.
	function automatic item_t random_item();
		logic [95:0] bits;
		bits = {$urandom, $urandom, $urandom};
		return bits[$bits(item_t)-1:0];
	endfunction

	function automatic item_t make_header(logic som, logic eom, logic [2:0] tag, logic owner,
			logic [7:0] mtype, logic [SEQ_W-1:0] seq, logic [PLEN_W-1:0] plen,
			logic [TIME_WIDTH-1:0] now);
		item_t it;
		it = random_item();
		it.kind = KIND_HEADER;
		it.start_of_message = som;
		it.end_of_message = eom;
		it.message_tag = tag;
		it.tag_owner = owner;
		it.message_type = mtype;
		it.packet_sequence = seq;
		it.payload_length = plen;
		it.time_now = now;
		return it;
	endfunction

	function automatic item_t make_payload(logic [7:0] data);
		item_t it;
		it = random_item();
		it.kind = KIND_PAYLOAD;
		it.data_byte = data;
		return it;
	endfunction

	function automatic item_t make_read(logic [IDX_W-1:0] idx);
		item_t it;
		it = random_item();
		it.kind = KIND_READ;
		it.read_index = idx;
		return it;
	endfunction

	task automatic drive_fields(item_t it);
		req_bus.kind <= it.kind;
		req_bus.start_of_message <= it.start_of_message;
		req_bus.end_of_message <= it.end_of_message;
		req_bus.message_tag <= it.message_tag;
		req_bus.tag_owner <= it.tag_owner;
		req_bus.message_type <= it.message_type;
		req_bus.packet_sequence <= it.packet_sequence;
		req_bus.payload_length <= it.payload_length;
		req_bus.data_byte <= it.data_byte;
		req_bus.read_index <= it.read_index;
		req_bus.time_now <= it.time_now;
	endtask

	// Offers one request after an optional idle gap and records the
	// predicted outcome once the transfer has taken place. Valid stays high
	// afterwards, so that a following call with no gap runs back to back.
	task automatic send_item(item_t it);
		int unsigned pause;
		pause = source_idle ? $urandom_range(0, 19) : 0;
		if (pause > 0) begin
			req_bus.valid <= 1'b0;
			repeat (pause) @(posedge clk);
		end
		req_bus.valid <= 1'b1;
		drive_fields(it);
		do @(posedge clk); while (!req_bus.ready);
		if (!(it.kind == KIND_UNUSED || (it.kind == KIND_PAYLOAD && !in_payload)))
			counted_items++;
		expected_outcomes.push_back(reassemble(it));
	endtask

	// Takes valid down and waits until every owed response has arrived.
	task automatic wait_for_results();
		req_bus.valid <= 1'b0;
		do @(posedge clk); while (expected_outcomes.size() != 0);
	endtask

	// The register is only written with the block drained.
	task automatic set_timeout(logic [TIME_WIDTH-1:0] ticks);
		wait_for_results();
		cfg_we <= 1'b1;
		cfg_wdata <= ticks;
		@(posedge clk);
		cfg_we <= 1'b0;
		gap_limit = ticks;
	endtask

	// Tag, owner, type and sequence at their top values, payload bytes at
	// both extremes, then reads inside, just past and far beyond the message.
	task automatic test_single_packet();
		send_item(make_header(1'b1, 1'b1, 3'd7, 1'b1, 8'hFF, 2'd3, 7'd2, TIME_MAX));
		send_item(make_payload(8'h00));
		send_item(make_payload(8'hFF));
		send_item(make_read(12'd1));
		send_item(make_read(12'd2));
		send_item(make_read(12'hFFF));
		wait_for_results();
	endtask

	// An empty EOM packet completes at once with length zero, which also
	// hides the earlier message from reads. Stray bytes and the unused kind
	// are ignored.
	task automatic test_empty_message();
		item_t noise;
		send_item(make_header(1'b1, 1'b1, 3'd0, 1'b0, 8'h00, 2'd0, 7'd0, '0));
		send_item(make_read(12'd0));
		send_item(make_payload(8'h5A));
		noise = random_item();
		noise.kind = KIND_UNUSED;
		send_item(noise);
		wait_for_results();
	endtask

	// Each header check but the timeout in turn; every one after the no-SOM case follows or carries a fresh SOM.
	task automatic test_header_checks();
		send_item(make_header(1'b0, 1'b0, 3'd1, 1'b0, 8'h10, 2'd0, 7'd0, 32'd5));
		send_item(make_header(1'b1, 1'b0, 3'd1, 1'b0, 8'h10, 2'd0, 7'd0, 32'd5));
		send_item(make_header(1'b0, 1'b0, 3'd2, 1'b0, 8'h10, 2'd1, 7'd0, 32'd6));
		send_item(make_header(1'b1, 1'b0, 3'd1, 1'b0, 8'h10, 2'd0, 7'd0, 32'd7));
		send_item(make_header(1'b0, 1'b0, 3'd1, 1'b1, 8'h10, 2'd1, 7'd0, 32'd8));
		send_item(make_header(1'b1, 1'b0, 3'd1, 1'b0, 8'h10, 2'd0, 7'd0, 32'd9));
		send_item(make_header(1'b0, 1'b1, 3'd1, 1'b0, 8'h11, 2'd1, 7'd0, 32'd10));
		send_item(make_header(1'b1, 1'b0, 3'd1, 1'b0, 8'h10, 2'd2, 7'd0, 32'd11));
		send_item(make_header(1'b0, 1'b1, 3'd1, 1'b0, 8'h10, 2'd0, 7'd0, 32'd12));
		// One byte more than a packet may carry.
		send_item(make_header(1'b1, 1'b1, 3'd1, 1'b0, 8'h10, 2'd0, 7'd65, 32'd13));
		wait_for_results();
	endtask

	// A header that arrives while payload is still owed: a SOM restarts the
	// message, anything else finds no assembly left.
	task automatic test_interrupted_packet();
		send_item(make_header(1'b1, 1'b0, 3'd4, 1'b0, 8'h22, 2'd1, 7'd2, 32'd20));
		send_item(make_payload(8'hA5));
		send_item(make_header(1'b1, 1'b1, 3'd4, 1'b0, 8'h22, 2'd1, 7'd1, 32'd21));
		send_item(make_payload(8'h3C));
		send_item(make_read(12'd0));
		send_item(make_header(1'b1, 1'b0, 3'd4, 1'b0, 8'h22, 2'd1, 7'd3, 32'd22));
		send_item(make_payload(8'h81));
		send_item(make_header(1'b0, 1'b1, 3'd4, 1'b0, 8'h22, 2'd2, 7'd0, 32'd23));
		wait_for_results();
	endtask

	// With the reset limit of 1000: a gap of exactly the limit passes and the
	// sequence wraps from 3 to 0, one tick more aborts even a SOM, and the
	// time difference is taken across the wrap of the time stamp.
	task automatic test_timeout();
		send_item(make_header(1'b1, 1'b0, 3'd3, 1'b0, 8'h7E, 2'd3, 7'd0, 32'd100));
		send_item(make_header(1'b0, 1'b0, 3'd3, 1'b0, 8'h7E, 2'd0, 7'd0, 32'd1100));
		send_item(make_header(1'b1, 1'b1, 3'd3, 1'b0, 8'h7E, 2'd0, 7'd0, 32'd2101));
		send_item(make_header(1'b1, 1'b1, 3'd3, 1'b0, 8'h7E, 2'd0, 7'd0, 32'd2101));
		send_item(make_header(1'b1, 1'b0, 3'd5, 1'b1, 8'h01, 2'd0, 7'd0, TIME_MAX - 10));
		send_item(make_header(1'b0, 1'b1, 3'd5, 1'b1, 8'h01, 2'd1, 7'd0, 32'd500));
		wait_for_results();
	endtask

	// The response side holds ready low for a long stretch while requests
	// keep coming, so the block fills and has to stall its input.
	task automatic test_backpressure();
		source_idle = 1'b0;
		hold_request = 150;
		send_item(make_header(1'b1, 1'b1, 3'd6, 1'b0, 8'h42, 2'd2, 7'd20, stamp));
		repeat (20) send_item(make_payload(8'($urandom)));
		repeat (4) send_item(make_read(IDX_W'($urandom_range(0, 24))));
		wait_for_results();
		source_idle = 1'b1;
	endtask

	// One message of up to four packets with random content. Most are clean
	// so that the later packets are reached; the rest carry one flaw in a
	// chosen packet. A few reads follow.
	task automatic send_random_message();
		logic [2:0]            tag;
		logic                  owner;
		logic [7:0]            mtype;
		logic [SEQ_W-1:0]      seq;
		logic [TIME_WIDTH-1:0] step;
		item_t                 hdr;
		item_t                 noise;
		flaw_t                 flaw;
		int unsigned           packets;
		int unsigned           flaw_at;
		int unsigned           plen;
		int unsigned           sent;
		int unsigned           idx;
		tag = 3'($urandom);
		owner = 1'($urandom);
		mtype = 8'($urandom);
		seq = SEQ_W'($urandom);
		packets = $urandom_range(1, 4);
		flaw = ($urandom_range(0, 9) < 7) ? FLAW_NONE : flaw_t'($urandom_range(1, 10));
		flaw_at = $urandom_range(0, packets - 1);
		// Each side runs a message with no idling one time in four, independently of the other side.
		source_idle = $urandom_range(0, 3) != 0;
		sink_idle = $urandom_range(0, 3) != 0;
		for (int p = 0; p < packets; p++) begin
			plen = ($urandom_range(0, 4) == 0) ? $urandom_range(0, PACKET_MTU)
					: $urandom_range(0, 6);
			if (p == flaw_at && flaw == FLAW_LATE && gap_limit < TIME_MAX - 1000) begin
				step = gap_limit + 1 + TIME_WIDTH'($urandom_range(0, 999));
			end else begin
				case ($urandom_range(0, 3))
					0: step = '0;
					1: step = gap_limit;
					default: step = TIME_WIDTH'($urandom_range(0, gap_limit));
				endcase
			end
			stamp = stamp + step;
			hdr = make_header(p == 0, p == packets - 1, tag, owner, mtype, SEQ_W'(seq + p),
					PLEN_W'(plen), stamp);
			if (p == flaw_at) begin
				case (flaw)
					FLAW_TAG: hdr.message_tag = tag ^ 3'($urandom_range(1, 7));
					FLAW_OWNER: hdr.tag_owner = !owner;
					FLAW_TYPE: hdr.message_type = mtype ^ 8'($urandom_range(1, 255));
					FLAW_SEQ: hdr.packet_sequence = SEQ_W'(seq + p + $urandom_range(1, 3));
					FLAW_NO_SOM: hdr.start_of_message = 1'b0;
					FLAW_OVERSIZE: hdr.payload_length = PLEN_W'($urandom_range(PACKET_MTU + 1, 127));
					FLAW_NOISE: begin
						noise = random_item();
						noise.kind = KIND_UNUSED;
						send_item(noise);
					end
					default: ;
				endcase
			end
			send_item(hdr);
			sent = plen;
			// A short packet leaves payload owed, so the next header cuts into it.
			if (p == flaw_at && flaw == FLAW_SHORT && plen > 0)
				sent = $urandom_range(0, plen - 1);
			repeat (sent) send_item(make_payload(8'($urandom)));
			if (p == flaw_at && flaw == FLAW_STRAY)
				repeat ($urandom_range(1, 2)) send_item(make_payload(8'($urandom)));
		end
		repeat ($urandom_range(0, 3)) begin
			// Mostly inside the message, with the top draw just past its end.
			if (completed_bytes > 0 && $urandom_range(0, 2) != 0)
				idx = $urandom_range(0, completed_bytes);
			else
				idx = $urandom_range(0, 4095);
			send_item(make_read(IDX_W'(idx)));
		end
	endtask

	// Random traffic under the reset limit, both extremes and two random
	// limits; each setting starts from a random point in time.
	task automatic test_random_traffic();
		logic [TIME_WIDTH-1:0] settings [TIMEOUT_SETTINGS];
		int unsigned           goal;
		settings = '{TIMEOUT_RESET, '0, TIME_MAX, TIME_WIDTH'($urandom),
				TIME_WIDTH'($urandom_range(1, 5000))};
		for (int ph = 0; ph < TIMEOUT_SETTINGS; ph++) begin
			set_timeout(settings[ph]);
			stamp = TIME_WIDTH'($urandom);
			goal = counted_items + RANDOM_ITEMS / TIMEOUT_SETTINGS;
			while (counted_items < goal)
				send_random_message();
		end
		wait_for_results();
	endtask

	// Response side: a random stall before each transfer, plus any long
	// hold that a test has asked for.
	initial begin : response_side
		int unsigned stall;
		rsp_bus.ready <= 1'b0;
		do @(posedge clk); while (!arst_n);
		forever begin
			stall = hold_request + (sink_idle ? $urandom_range(0, 19) : 0);
			hold_request = 0;
			if (stall > 0) begin
				rsp_bus.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_bus.ready <= 1'b1;
			do @(posedge clk); while (!rsp_bus.valid && hold_request == 0);
		end
	end

	// Every response transfer is matched against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && rsp_bus.valid && rsp_bus.ready) begin
			if (expected_outcomes.size() == 0) begin
				$error("response transfer with no request outstanding");
				mismatches++;
			end else begin
				due = expected_outcomes.pop_front();
				checked_results++;
				status_seen[due.status]++;
				if (rsp_bus.status !== due.status) begin
					$error("status: expected %0d, got %0d", due.status, rsp_bus.status);
					mismatches++;
				end
				if (rsp_bus.message_length !== due.length) begin
					$error("message_length: expected %0d, got %0d", due.length,
							rsp_bus.message_length);
					mismatches++;
				end
				if (rsp_bus.read_byte !== due.data) begin
					$error("read_byte: expected 0x%02h, got 0x%02h", due.data, rsp_bus.read_byte);
					mismatches++;
				end
				if (rsp_bus.read_valid !== due.valid) begin
					$error("read_valid: expected %0d, got %0d", due.valid, rsp_bus.read_valid);
					mismatches++;
				end
			end
		end
	end

	// Ends the run if neither channel has moved a transfer for too long.
	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("mctp_message_reassembler_test: FAIL");
		$finish;
	end

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		req_bus.valid <= 1'b0;
		drive_fields('0);
		// Predicted state after reset. The store starts at zero, although no
		// read ever reaches a byte that was not written.
		gap_limit = TIMEOUT_RESET;
		abandon_assembly();
		held_type = '0;
		last_header_time = '0;
		completed_bytes = 0;
		stamp = '0;
		for (int i = 0; i < MAX_MESSAGE_BYTES; i++)
			message_store[i] = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		test_single_packet();
		test_empty_message();
		test_header_checks();
		test_interrupted_packet();
		test_timeout();
		test_backpressure();
		test_random_traffic();

		wait_for_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Checked %0d responses for %0d requests over %0d timeout settings.",
				checked_results, counted_items, TIMEOUT_SETTINGS);
		$display("Outcomes: ok %0d, complete %0d, timeout %0d, no SOM %0d,",
				status_seen[ST_OK], status_seen[ST_DONE], status_seen[ST_TIMEOUT],
				status_seen[ST_NOSOM]);
		$display("  tag %0d, seq/type %0d, overflow %0d.",
				status_seen[ST_TAG], status_seen[ST_SEQ], status_seen[ST_OVERFLOW]);
		if (mismatches == 0 && expected_outcomes.size() == 0)
			$display("mctp_message_reassembler_test: PASS");
		else
			$display("mctp_message_reassembler_test: FAIL");
		$finish;
	end

endmodule

FILE: mctp_message_reassembler.f
+incdir+rtl
rtl/mmr_pkg.sv
rtl/mmr_req_if.sv
rtl/mmr_rsp_if.sv
rtl/mmr_ram.sv
rtl/mmr_ctrl.sv
rtl/mctp_message_reassembler.sv
rtl/mmr_checker.sv
tb/mctp_message_reassembler_test.sv
